FILE: rtl/core/mtrr_pkg.sv
`timescale 1ns / 1ps

package mtrr_pkg;

	// table geometry
	localparam int MAX_RANGES = 16;
	localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CNT_W      = $clog2(MAX_RANGES + 1);

	// field widths
	localparam int FRAME_W = 40;
	localparam int LAST_W  = FRAME_W + 1;
	localparam int PAGE_W  = 18;
	localparam int KIND_W  = 3;
	localparam int STS_W   = 3;

	// 2 MB page expressed in 4 KB frames
	localparam int BIG_SHIFT = 9;
	localparam int PAD_W     = LAST_W - PAGE_W - BIG_SHIFT;

	// operand width of the shared adder
	localparam int OPW = LAST_W;

	// opcodes
	localparam logic OP_ADD     = 1'b0;
	localparam logic OP_RESOLVE = 1'b1;

	// memory types
	localparam logic [KIND_W-1:0] TYPE_UC = 3'd0;
	localparam logic [KIND_W-1:0] TYPE_WB = 3'd6;

	// result status codes
	localparam logic [STS_W-1:0] STS_RESOLVED = 3'd0;
	localparam logic [STS_W-1:0] STS_STORED   = 3'd1;
	localparam logic [STS_W-1:0] STS_SKIPPED  = 3'd2;
	localparam logic [STS_W-1:0] STS_FULL     = 3'd3;
	localparam logic [STS_W-1:0] STS_EMPTY    = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SIZE,
		ST_STORE,
		ST_CMP_LAST,
		ST_CMP_BASE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               opcode;
		logic [FRAME_W-1:0] base_frame;
		logic [KIND_W-1:0]  range_type;
		logic [FRAME_W-1:0] mask_frame;
		logic               mask_valid;
		logic [PAGE_W-1:0]  page_number;
	} req_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] mem_type;
		logic [STS_W-1:0]  status;
	} rsp_item_t;

	// one stored range, in 4 KB frames
	typedef struct packed {
		logic [FRAME_W-1:0] start_frame;
		logic [LAST_W-1:0]  last_frame;
		logic [KIND_W-1:0]  kind;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		entry_t            entry;
	} tbl_wr_t;

	// shared adder request: sub set means a - b with carry out as a >= b
	typedef struct packed {
		logic [OPW-1:0] a;
		logic [OPW-1:0] b;
		logic           sub;
	} alu_req_t;

	typedef struct packed {
		logic [OPW-1:0] sum;
		logic           carry;
	} alu_rsp_t;

endpackage

FILE: rtl/core/mtrr_if.sv
`timescale 1ns / 1ps

interface mtrr_req_if
	import mtrr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [FRAME_W-1:0] base_frame;
	logic [KIND_W-1:0]  range_type;
	logic [FRAME_W-1:0] mask_frame;
	logic               mask_valid;
	logic [PAGE_W-1:0]  page_number;

	modport source (
		output valid, opcode, base_frame, range_type, mask_frame, mask_valid, page_number,
		input  ready
	);
	modport sink (
		input  valid, opcode, base_frame, range_type, mask_frame, mask_valid, page_number,
		output ready
	);
endinterface

interface mtrr_rsp_if
	import mtrr_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] mem_type;
	logic [STS_W-1:0]  status;

	modport source (
		output valid, mem_type, status,
		input  ready
	);
	modport sink (
		input  valid, mem_type, status,
		output ready
	);
endinterface

FILE: rtl/core/mtrr_alu.sv
`timescale 1ns / 1ps

module mtrr_alu
	import mtrr_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [OPW-1:0] b_eff;
	logic [OPW:0]   total;

	// add, or subtract by inverting b and carrying in
	always_comb begin
		b_eff = req.sub ? ~req.b : req.b;
		total = {1'b0, req.a} + {1'b0, b_eff} + {{OPW{1'b0}}, req.sub};
		rsp.sum   = total[OPW-1:0];
		rsp.carry = total[OPW];
	end

endmodule

FILE: rtl/core/mtrr_table.sv
`timescale 1ns / 1ps

module mtrr_table
	import mtrr_pkg::*;
(
	input  logic             clk,
	input  tbl_wr_t          wr,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_entry
);

	entry_t mem [MAX_RANGES];

	// write one range
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.entry;
		end
	end

	// registered read, refreshed every cycle
	always_ff @(posedge clk) begin
		rd_entry <= mem[rd_addr];
	end

endmodule

FILE: rtl/core/mtrr_ctrl.sv
`timescale 1ns / 1ps

module mtrr_ctrl
	import mtrr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  req_item_t        req_item,
	output logic             ready,
	input  logic             out_free,
	output logic             done,
	output rsp_item_t        result,
	output alu_req_t         alu_req,
	input  alu_rsp_t         alu_rsp,
	output tbl_wr_t          tbl_wr,
	output logic [IDX_W-1:0] rd_addr,
	input  entry_t           rd_entry
);

	state_t             state_q, state_d;
	req_item_t          item_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic [KIND_W-1:0]  kind_q;
	logic [STS_W-1:0]   status_q;
	logic [FRAME_W-1:0] span_q;

	logic [CNT_W-1:0]   idx_next;
	logic               last_entry;
	logic               ge;
	logic               uc_hit;
	logic               adv;
	logic               add_skip;
	logic               add_empty;
	logic               add_full;

	// walk bookkeeping
	always_comb begin
		idx_next   = CNT_W'(idx_q) + CNT_W'(1);
		last_entry = (idx_next == count_q);
		ge         = alu_rsp.carry;
		uc_hit     = ge && (rd_entry.kind == TYPE_UC);
		adv        = ((state_q == ST_CMP_LAST) && !ge) ||
		             ((state_q == ST_CMP_BASE) && !uc_hit);
		add_skip   = !item_q.mask_valid || (item_q.range_type == TYPE_WB);
		add_empty  = (item_q.mask_frame == '0);
		add_full   = (count_q >= CNT_W'(MAX_RANGES));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (item_q.opcode == OP_ADD) begin
					if (add_skip || add_empty || add_full) state_d = ST_DONE;
					else state_d = ST_SIZE;
				end else begin
					if ((item_q.page_number == '0) || (count_q == '0)) state_d = ST_DONE;
					else state_d = ST_CMP_LAST;
				end
			end
			ST_SIZE:  state_d = ST_STORE;
			ST_STORE: state_d = ST_DONE;
			ST_CMP_LAST: begin
				if (ge) state_d = ST_CMP_BASE;
				else if (last_entry) state_d = ST_DONE;
			end
			ST_CMP_BASE: begin
				if (uc_hit || last_entry) state_d = ST_DONE;
				else state_d = ST_CMP_LAST;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and shared adder operands
	always_comb begin
		ready   = 1'b0;
		done    = 1'b0;
		alu_req = '0;
		tbl_wr  = '0;
		idx_d   = idx_q;
		case (state_q)
			ST_IDLE:   ready = 1'b1;
			ST_DECODE: idx_d = '0;
			ST_SIZE: begin
				// mask minus one
				alu_req.a   = {1'b0, item_q.mask_frame};
				alu_req.b   = OPW'(1);
				alu_req.sub = 1'b1;
			end
			ST_STORE: begin
				// last frame = base + bits below the lowest set mask bit
				alu_req.a          = {1'b0, item_q.base_frame};
				alu_req.b          = {1'b0, ~item_q.mask_frame & span_q};
				alu_req.sub        = 1'b0;
				tbl_wr.en          = 1'b1;
				tbl_wr.addr        = count_q[IDX_W-1:0];
				tbl_wr.entry.start_frame = item_q.base_frame;
				tbl_wr.entry.last_frame  = alu_rsp.sum;
				tbl_wr.entry.kind        = item_q.range_type;
			end
			ST_CMP_LAST: begin
				// range last frame against first frame of the page
				alu_req.a   = rd_entry.last_frame;
				alu_req.b   = {{PAD_W{1'b0}}, item_q.page_number, {BIG_SHIFT{1'b0}}};
				alu_req.sub = 1'b1;
				if (adv && !last_entry) idx_d = idx_next[IDX_W-1:0];
			end
			ST_CMP_BASE: begin
				// last frame of the page against range start frame
				alu_req.a   = {{PAD_W{1'b0}}, item_q.page_number, {BIG_SHIFT{1'b1}}};
				alu_req.b   = {1'b0, rd_entry.start_frame};
				alu_req.sub = 1'b1;
				if (adv && !last_entry) idx_d = idx_next[IDX_W-1:0];
			end
			ST_DONE: done = out_free;
			default: ;
		endcase
		rd_addr = idx_d;
		result.mem_type = kind_q;
		result.status   = status_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (state_q == ST_STORE) count_q <= count_q + CNT_W'(1);
		end
	end

	// transaction payload and running result
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && req_valid) item_q <= req_item;
		if (state_q == ST_SIZE) span_q <= alu_rsp.sum[FRAME_W-1:0];
		if (state_q == ST_DECODE) begin
			if (item_q.opcode == OP_ADD) begin
				kind_q <= TYPE_UC;
				if (add_skip)       status_q <= STS_SKIPPED;
				else if (add_empty) status_q <= STS_EMPTY;
				else if (add_full)  status_q <= STS_FULL;
				else                status_q <= STS_STORED;
			end else begin
				status_q <= STS_RESOLVED;
				kind_q   <= (item_q.page_number == '0) ? TYPE_UC : TYPE_WB;
			end
		end
		// overlap found: the later range takes over
		if ((state_q == ST_CMP_BASE) && ge) kind_q <= rd_entry.kind;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RANGES))
		else $error("range count beyond table depth");

	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr.en |-> (count_q < CNT_W'(MAX_RANGES)))
		else $error("range stored into a full table");

	a_walk_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CMP_LAST) || (state_q == ST_CMP_BASE)) |->
		(CNT_W'(idx_q) < count_q))
		else $error("walk index past stored ranges");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && ready) |=> (state_q == ST_DECODE))
		else $error("accepted transaction not decoded");

	a_resolve_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (item_q.opcode == OP_RESOLVE)) |-> (status_q == STS_RESOLVED))
		else $error("resolve result carries an add status");

endmodule

FILE: rtl/core/mtrr_memory_type_resolver_unit.sv
`timescale 1ns / 1ps
// A rejected add, and a resolve of page 0 or of an empty table, go from decode straight
// to done; a stored add passes through the size and store states first, and a resolve
// over N stored ranges makes up to two compares per range on the one shared adder.
// One transaction at a time; the next is taken once the result has moved
// into the output register. Reset clears the range count, the sequencer and the output
// valid only; table contents stay undefined until written, and no clearing pass is run.

module mtrr_memory_type_resolver_unit
	import mtrr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	mtrr_req_if.sink   req,
	mtrr_rsp_if.source rsp
);

	req_item_t        req_item;
	rsp_item_t        result;
	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;
	tbl_wr_t          tbl_wr;
	entry_t           rd_entry;
	logic [IDX_W-1:0] rd_addr;
	logic             ctrl_ready;
	logic             done;
	logic             out_free;
	logic             out_valid_q;
	rsp_item_t        out_q;

	// gather the request payload
	always_comb begin
		req_item.opcode      = req.opcode;
		req_item.base_frame  = req.base_frame;
		req_item.range_type  = req.range_type;
		req_item.mask_frame  = req.mask_frame;
		req_item.mask_valid  = req.mask_valid;
		req_item.page_number = req.page_number;
	end

	assign req.ready = ctrl_ready;
	assign out_free  = !out_valid_q || rsp.ready;

	mtrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_item  (req_item),
		.ready     (ctrl_ready),
		.out_free  (out_free),
		.done      (done),
		.result    (result),
		.alu_req   (alu_req),
		.alu_rsp   (alu_rsp),
		.tbl_wr    (tbl_wr),
		.rd_addr   (rd_addr),
		.rd_entry  (rd_entry)
	);

	mtrr_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	mtrr_table u_table (
		.clk      (clk),
		.wr       (tbl_wr),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry)
	);

	// hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) out_q <= result;
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.mem_type = out_q.mem_type;
	assign rsp.status   = out_q.status;

endmodule

FILE: sim/mtrr_memory_type_resolver_unit_tb.sv
`timescale 1ns / 1ps

module mtrr_memory_type_resolver_unit_tb;
	import mtrr_pkg::*;

	// memory types other than the two the package names
	localparam logic [KIND_W-1:0] TYPE_WC    = 3'd1;
	localparam logic [KIND_W-1:0] TYPE_RSVD2 = 3'd2;
	localparam logic [KIND_W-1:0] TYPE_RSVD3 = 3'd3;
	localparam logic [KIND_W-1:0] TYPE_WT    = 3'd4;
	localparam logic [KIND_W-1:0] TYPE_WP    = 3'd5;
	localparam logic [KIND_W-1:0] TYPE_RSVD7 = 3'd7;

	localparam int FRAME_SHIFT  = 12;
	localparam int PAGE2M_SHIFT = 21;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n;

	mtrr_req_if req_bus ();
	mtrr_rsp_if rsp_bus ();

	mtrr_memory_type_resolver_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the range table, byte addresses
	logic [63:0]       tbl_base_addr [MAX_RANGES];
	logic [63:0]       tbl_end_addr  [MAX_RANGES];
	logic [KIND_W-1:0] tbl_type      [MAX_RANGES];
	int                tbl_used = 0;

	rsp_item_t expected_outcomes [$];
	int        errors      = 0;
	int        idle_cycles = 0;
	int        burst_left  = 0;
	int        stall_span  = 0;
	logic [11:0] stall_pat = '1;

	// work out the result of one transaction and update the shadow table
	function automatic rsp_item_t predict_outcome(input req_item_t it);
		rsp_item_t   r;
		logic [63:0] lo;
		logic [63:0] hi;
		int          k;
		logic        stop;
		r.mem_type = TYPE_UC;
		r.status   = STS_RESOLVED;
		if (it.opcode == OP_ADD) begin
			if (!it.mask_valid || it.range_type == TYPE_WB) begin
				r.status = STS_SKIPPED;
			end else if (it.mask_frame == '0) begin
				r.status = STS_EMPTY;
			end else if (tbl_used >= MAX_RANGES) begin
				r.status = STS_FULL;
			end else begin
				k = 0;
				while (!it.mask_frame[k]) k++;
				lo = 64'(it.base_frame) << FRAME_SHIFT;
				tbl_base_addr[tbl_used] = lo;
				tbl_end_addr[tbl_used]  = lo + ((64'd1 << (k + FRAME_SHIFT)) - 64'd1);
				tbl_type[tbl_used]      = it.range_type;
				tbl_used++;
				r.status = STS_STORED;
			end
		end else if (it.page_number != '0) begin
			lo   = 64'(it.page_number) << PAGE2M_SHIFT;
			hi   = lo + ((64'd1 << PAGE2M_SHIFT) - 64'd1);
			stop = 1'b0;
			r.mem_type = TYPE_WB;
			// last overlapping range wins; an uncacheable hit ends the walk
			for (int i = 0; i < tbl_used; i++) begin
				if (!stop && lo <= tbl_end_addr[i] && hi >= tbl_base_addr[i]) begin
					r.mem_type = tbl_type[i];
					stop = (tbl_type[i] == TYPE_UC);
				end
			end
		end
		return r;
	endfunction

	function automatic logic [FRAME_W-1:0] rand40();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[FRAME_W-1:0];
	endfunction

	function automatic req_item_t make_add(input logic [FRAME_W-1:0] base,
			input logic [KIND_W-1:0] kind, input logic [FRAME_W-1:0] mask,
			input logic valid);
		req_item_t it;
		it.opcode      = OP_ADD;
		it.base_frame  = base;
		it.range_type  = kind;
		it.mask_frame  = mask;
		it.mask_valid  = valid;
		it.page_number = PAGE_W'($urandom());
		return it;
	endfunction

	function automatic req_item_t make_resolve(input logic [PAGE_W-1:0] page);
		req_item_t it;
		it.opcode      = OP_RESOLVE;
		it.base_frame  = rand40();
		it.range_type  = KIND_W'($urandom());
		it.mask_frame  = rand40();
		it.mask_valid  = 1'($urandom());
		it.page_number = page;
		return it;
	endfunction

	// valid pair, non write-back, base low enough to overlap real pages
	function automatic req_item_t random_range_add();
		int                 j;
		logic [FRAME_W-1:0] base;
		logic [FRAME_W-1:0] mask;
		logic [KIND_W-1:0]  kind;
		case ($urandom_range(0, 9))
			0:       j = $urandom_range(27, 39);
			1, 2, 3: j = $urandom_range(13, 26);
			default: j = $urandom_range(0, 12);
		endcase
		base = FRAME_W'($urandom_range(0, (1 << 27) - 1));
		if ($urandom_range(0, 1) == 1) base = base & ~((40'd1 << j) - 40'd1);
		mask = (rand40() | (40'd1 << j)) & ~((40'd1 << j) - 40'd1);
		do kind = KIND_W'($urandom()); while (kind == TYPE_WB);
		return make_add(base, kind, mask, 1'b1);
	endfunction

	// mostly rejected pairs, now and then a fully random one
	function automatic req_item_t noise_add();
		logic [FRAME_W-1:0] mask;
		logic [KIND_W-1:0]  kind;
		logic               valid;
		mask  = rand40();
		kind  = KIND_W'($urandom());
		valid = 1'($urandom());
		case ($urandom_range(0, 3))
			0:       valid = 1'b0;
			1:       kind  = TYPE_WB;
			2:       mask  = '0;
			default: ;
		endcase
		return make_add(rand40(), kind, mask, valid);
	endfunction

	// probe near range edges most of the time
	function automatic logic [PAGE_W-1:0] pick_probe_page();
		logic [63:0] addr;
		longint      p;
		int          i;
		if (tbl_used > 0 && $urandom_range(0, 9) < 7) begin
			i    = $urandom_range(0, tbl_used - 1);
			addr = ($urandom_range(0, 1) == 1) ? tbl_base_addr[i] : tbl_end_addr[i];
			p    = longint'(addr >> PAGE2M_SHIFT) + longint'($urandom_range(0, 2)) - 1;
			if (p >= 0 && p < (longint'(1) << PAGE_W)) return PAGE_W'(p);
		end
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return '1;
			default: return PAGE_W'($urandom());
		endcase
	endfunction

	// drive one transaction in bursts with random gaps; record its result on acceptance
	task automatic send_item(input req_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_bus.valid       <= 1'b1;
		req_bus.opcode      <= it.opcode;
		req_bus.base_frame  <= it.base_frame;
		req_bus.range_type  <= it.range_type;
		req_bus.mask_frame  <= it.mask_frame;
		req_bus.mask_valid  <= it.mask_valid;
		req_bus.page_number <= it.page_number;
		do @(posedge clk); while (!req_bus.ready);
		expected_outcomes.push_back(predict_outcome(it));
	endtask

	// hold the sender until every outstanding result has come back
	task automatic wait_drained();
		req_bus.valid <= 1'b0;
		do @(posedge clk); while (expected_outcomes.size() != 0);
	endtask

	task automatic test_empty_table();
		send_item(make_resolve('0));
		send_item(make_resolve(PAGE_W'(1)));
		send_item(make_resolve('1));
		send_item(make_add(40'h200, TYPE_WC, '1, 1'b0));
		send_item(make_add(40'h200, TYPE_WB, '1, 1'b1));
		// invalid pair with empty mask: the invalid check comes first
		send_item(make_add(40'h200, TYPE_WC, '0, 1'b0));
		send_item(make_add(40'h200, TYPE_WC, '0, 1'b1));
		send_item(make_resolve(PAGE_W'(1)));
	endtask

	task automatic test_directed_ranges();
		int probes [10] = '{1, 2, 3, 4, 5, 9, 10, 131071, 131072, 262143};
		send_item(make_add(40'h200, TYPE_WC, '1, 1'b1));
		send_item(make_add(40'h400, TYPE_WP, 40'hFF_FFFF_FE00, 1'b1));
		send_item(make_add(40'h300, TYPE_RSVD7, 40'hFF_FFFF_F000, 1'b1));
		send_item(make_add(40'h600, TYPE_UC, 40'hFF_FFFF_FE00, 1'b1));
		send_item(make_add(40'h600, TYPE_WT, '1, 1'b1));
		send_item(make_add(40'h400_0000, TYPE_RSVD2, 40'hFF_FC00_0000, 1'b1));
		// top base with the widest mask: end address needs the full width
		send_item(make_add('1, TYPE_RSVD3, 40'h80_0000_0000, 1'b1));
		foreach (probes[n])
			send_item(make_resolve(PAGE_W'(probes[n])));
	endtask

	task automatic test_random_traffic(input int n_items);
		int pick;
		repeat (n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) send_item(random_range_add());
			else if (pick < 17) send_item(noise_add());
			else send_item(make_resolve(pick_probe_page()));
		end
	endtask

	task automatic test_table_full();
		while (tbl_used < MAX_RANGES) send_item(random_range_add());
		send_item(random_range_add());
		send_item(make_add(40'h1000, TYPE_WC, '0, 1'b1));
		send_item(make_add(40'h1000, TYPE_WB, '1, 1'b1));
		send_item(make_add(40'h1000, TYPE_UC, '1, 1'b1));
		wait_drained();
	endtask

	// receiver stalls on a rotating pattern, reloaded now and then
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_span <= $urandom_range(20, 200);
			stall_pat  <= ($urandom_range(0, 3) == 0) ? 12'hFFF : 12'($urandom());
		end else begin
			stall_span <= stall_span - 1;
			stall_pat  <= {stall_pat[10:0], stall_pat[11]};
		end
		rsp_bus.ready <= stall_pat[0];
	end

	// compare each result with the oldest expectation; watch for a hang
	always @(posedge clk) begin : check_results
		rsp_item_t want;
		if (rsp_bus.valid && rsp_bus.ready) begin
			if (expected_outcomes.size() == 0) begin
				$error("unexpected result: mem_type %0d status %0d",
					rsp_bus.mem_type, rsp_bus.status);
				errors++;
			end else begin
				want = expected_outcomes.pop_front();
				if (rsp_bus.mem_type !== want.mem_type) begin
					$error("mem_type: expected %0d, actual %0d",
						want.mem_type, rsp_bus.mem_type);
					errors++;
				end
				if (rsp_bus.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
					errors++;
				end
			end
		end
		if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("mtrr_memory_type_resolver_unit verification failed");
			$finish;
		end
	end

	initial begin
		arst_n              <= 1'b0;
		req_bus.valid       <= 1'b0;
		req_bus.opcode      <= OP_ADD;
		req_bus.base_frame  <= '0;
		req_bus.range_type  <= TYPE_UC;
		req_bus.mask_frame  <= '0;
		req_bus.mask_valid  <= 1'b0;
		req_bus.page_number <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		wait_drained();
		test_directed_ranges();
		wait_drained();
		test_random_traffic(270);
		wait_drained();
		test_table_full();
		test_random_traffic(260);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && expected_outcomes.size() == 0)
			$display("mtrr_memory_type_resolver_unit verification clean");
		else
			$display("mtrr_memory_type_resolver_unit verification failed");
		$finish;
	end

endmodule
